### hdl/eef_pkg.sv
// shared constants and control types for the envelope extrema finder
package eef_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int MAX_LENGTH_DEF    = 65536;
    localparam int FRACTION_BITS_DEF = 8;

    // fixed result field widths
    localparam int CNT_W  = 16;
    localparam int POSH_W = 17;
    localparam int VAL_W  = 32;

    // list kind codes
    localparam logic KIND_MAX = 1'b0;
    localparam logic KIND_MIN = 1'b1;

    // endpoint codes in emit order
    localparam logic [1:0] EP_LMAX = 2'd0;
    localparam logic [1:0] EP_RMAX = 2'd1;
    localparam logic [1:0] EP_LMIN = 2'd2;
    localparam logic [1:0] EP_RMIN = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic       step;
        logic       ep_init;
        logic       mul;
        logic       sum;
        logic       fin;
        logic       emit_ep;
        logic       emit_one;
        logic       one_min;
        logic       clear;
        logic [1:0] ep;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic step_emit;
        logic last;
        logic one;
        logic ep_try;
        logic out_free;
    } t_sts;

endpackage

### hdl/eef_in_if.sv
// sample request channel
interface eef_in_if #(
    parameter int SAMPLE_BITS = eef_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

### hdl/eef_out_if.sv
// extremum result request channel
interface eef_out_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [eef_pkg::CNT_W-1:0]         ordinal;
    logic [eef_pkg::POSH_W-1:0]        position_half;
    logic signed [eef_pkg::VAL_W-1:0]  value;
    logic                              final_res;
    logic [eef_pkg::CNT_W-1:0]         max_count;
    logic [eef_pkg::CNT_W-1:0]         min_count;
    logic                              all_good;

    modport source (output valid, output kind, output ordinal, output position_half,
                    output value, output final_res, output max_count, output min_count,
                    output all_good, input ready);
    modport sink (input valid, input kind, input ordinal, input position_half,
                  input value, input final_res, input max_count, input min_count,
                  input all_good, output ready);
endinterface

### hdl/eef_div.sv
// restoring divider, one quotient bit per cycle
module eef_div #(
    parameter int DVD_W = 45,
    parameter int DEN_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_sh;
    logic             w_ge;

    // shifted partial remainder and trial subtract
    assign w_sh = {r_rem[DEN_W-1:0], r_q[DVD_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

### hdl/eef_dp.sv
// slope tracking, extremum lists, endpoint extrapolation and output register
module eef_dp #(
    parameter int SAMPLE_BITS   = eef_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_LENGTH    = eef_pkg::MAX_LENGTH_DEF,
    parameter int FRACTION_BITS = eef_pkg::FRACTION_BITS_DEF,
    parameter int POS_W         = $clog2(MAX_LENGTH + 1) + 1,
    parameter int DVD_W         = SAMPLE_BITS + POS_W + 3 + FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_last,
    input  eef_pkg::t_cmd                     i_cmd,
    output eef_pkg::t_sts                     o_sts,
    output logic [DVD_W-1:0]                  o_dvd,
    output logic [POS_W-1:0]                  o_den,
    input  logic [DVD_W-1:0]                  i_quo,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_kind,
    output logic [eef_pkg::CNT_W-1:0]         o_ordinal,
    output logic [eef_pkg::POSH_W-1:0]        o_position_half,
    output logic signed [eef_pkg::VAL_W-1:0]  o_value,
    output logic                              o_final_res,
    output logic [eef_pkg::CNT_W-1:0]         o_max_count,
    output logic [eef_pkg::CNT_W-1:0]         o_min_count,
    output logic                              o_all_good
);
    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = eef_pkg::CNT_W;
    localparam int VW    = eef_pkg::VAL_W;
    localparam int IDX_W = POS_W - 1;
    localparam int PD_W  = ((POS_W > CW) ? POS_W : CW) + 1;
    localparam int NUM_W = SB + POS_W + 3;
    localparam int Q_W   = (DVD_W > 33) ? DVD_W : 33;
    localparam logic [IDX_W-1:0] LIM = IDX_W'(MAX_LENGTH - 1);
    localparam logic [CW-1:0]    CMAX = {CW{1'b1}};

    typedef enum logic [1:0] {
        SL_UP,
        SL_DOWN,
        SL_NONE
    } t_slope;

    // saturating counter steps
    function automatic logic [CW-1:0] inc1(input logic [CW-1:0] c);
        return (c == CMAX) ? CMAX : c + 1'b1;
    endfunction

    function automatic logic [CW-1:0] inc2(input logic [CW-1:0] c);
        return (c >= CMAX - 1'b1) ? CMAX : c + CW'(2);
    endfunction

    // sample to saturated fixed point
    function automatic logic signed [VW-1:0] fix(input logic signed [SB-1:0] x);
        logic signed [63:0] w;
        w = 64'(x) <<< FRACTION_BITS;
        if (w > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (w < -64'sh8000_0000) begin
            return 32'sh8000_0000;
        end else begin
            return w[VW-1:0];
        end
    endfunction

    // series state
    logic signed [SB-1:0] r_smp;
    logic                 r_last;
    logic signed [SB-1:0] r_prev;
    logic signed [SB-1:0] r_first;
    t_slope               r_slope;
    logic [CW-1:0]        r_flat;
    logic [IDX_W-1:0]     r_sidx;
    logic [CW-1:0]        r_maxc;
    logic [CW-1:0]        r_minc;
    logic                 r_good;
    logic [POS_W-1:0]     r_tpos;

    // first two and latest two interior extrema of each kind
    logic [POS_W-1:0]     r_emx_p [2];
    logic signed [SB-1:0] r_emx_v [2];
    logic [POS_W-1:0]     r_rmx_p [2];
    logic signed [SB-1:0] r_rmx_v [2];
    logic [POS_W-1:0]     r_emn_p [2];
    logic signed [SB-1:0] r_emn_v [2];
    logic [POS_W-1:0]     r_rmn_p [2];
    logic signed [SB-1:0] r_rmn_v [2];

    // extrapolation pipeline
    logic signed [VW-1:0]    r_val;
    logic signed [NUM_W-1:0] r_p1;
    logic signed [NUM_W-1:0] r_p2;
    logic                    r_neg;
    logic [NUM_W-1:0]        r_mag;

    // output register
    logic                 r_ov;
    logic                 r_o_kind;
    logic [CW-1:0]        r_o_ord;
    logic [POS_W-1:0]     r_o_pos;
    logic signed [VW-1:0] r_o_val;
    logic                 r_o_fin;
    logic [CW-1:0]        r_o_mc;
    logic [CW-1:0]        r_o_nc;
    logic                 r_o_good;

    logic                    w_rise;
    logic                    w_fall;
    logic                    w_emit_min;
    logic                    w_emit_max;
    logic [IDX_W-1:0]        w_pidx;
    logic [IDX_W-1:0]        w_idx;
    logic signed [PD_W-1:0]  w_pos_s;
    logic [POS_W-1:0]        w_ppos;
    logic [POS_W-1:0]        w_ap;
    logic [POS_W-1:0]        w_bp;
    logic signed [SB-1:0]    w_av;
    logic signed [SB-1:0]    w_bv;
    logic [POS_W-1:0]        w_t;
    logic [CW-1:0]           w_cnt;
    logic signed [POS_W:0]   w_sden;
    logic signed [SB:0]      w_diff;
    logic signed [POS_W:0]   w_dt;
    logic signed [NUM_W-1:0] w_num;
    logic [Q_W-1:0]          w_qx;
    logic signed [VW-1:0]    w_e;
    logic                    w_take;
    logic                    w_out_free;

    // slope decision on the held sample
    assign w_rise     = (r_smp > r_prev);
    assign w_fall     = (r_smp < r_prev);
    assign w_emit_min = (r_sidx != '0) && w_rise && (r_slope == SL_DOWN);
    assign w_emit_max = (r_sidx != '0) && w_fall && (r_slope == SL_UP);

    // candidate position: centre of any flat run, clamped at zero
    assign w_pidx  = ((r_sidx - 1'b1) < LIM) ? (r_sidx - 1'b1) : LIM;
    assign w_idx   = (r_sidx < LIM) ? r_sidx : LIM;
    assign w_pos_s = $signed(PD_W'({w_pidx, 1'b0})) - $signed(PD_W'(r_flat));
    assign w_ppos  = (w_pos_s < 0) ? '0 : POS_W'(w_pos_s);

    // endpoint operand selection
    always_comb begin
        unique case (i_cmd.ep)
            eef_pkg::EP_LMAX: begin
                w_ap = r_emx_p[0]; w_av = r_emx_v[0];
                w_bp = r_emx_p[1]; w_bv = r_emx_v[1];
                w_t = '0; w_cnt = r_maxc;
            end
            eef_pkg::EP_RMAX: begin
                w_ap = r_rmx_p[0]; w_av = r_rmx_v[0];
                w_bp = r_rmx_p[1]; w_bv = r_rmx_v[1];
                w_t = r_tpos; w_cnt = r_maxc;
            end
            eef_pkg::EP_LMIN: begin
                w_ap = r_emn_p[0]; w_av = r_emn_v[0];
                w_bp = r_emn_p[1]; w_bv = r_emn_v[1];
                w_t = '0; w_cnt = r_minc;
            end
            default: begin
                w_ap = r_rmn_p[0]; w_av = r_rmn_v[0];
                w_bp = r_rmn_p[1]; w_bv = r_rmn_v[1];
                w_t = r_tpos; w_cnt = r_minc;
            end
        endcase
    end

    // line through two points
    assign o_den  = w_bp - w_ap;
    assign w_sden = $signed({1'b0, o_den});
    assign w_diff = (SB+1)'(w_bv) - (SB+1)'(w_av);
    assign w_dt   = $signed({1'b0, w_t}) - $signed({1'b0, w_ap});
    assign w_num  = r_p1 + r_p2;
    assign o_dvd  = DVD_W'(r_mag) << FRACTION_BITS;

    // saturate the signed quotient
    assign w_qx = Q_W'(i_quo);
    always_comb begin
        if (!r_neg) begin
            w_e = (w_qx > Q_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(w_qx[VW-1:0]);
        end else begin
            w_e = (w_qx > Q_W'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(w_qx[VW-1:0]);
        end
    end
    assign w_take = i_cmd.ep[1] ? (w_e < r_val) : (w_e > r_val);

    assign w_out_free = !r_ov || i_out_ready;

    // status
    assign o_sts.step_emit = w_emit_min || w_emit_max;
    assign o_sts.last      = r_last;
    assign o_sts.one       = (r_sidx == '0);
    assign o_sts.ep_try    = (w_cnt >= CW'(2)) && (w_bp > w_ap);
    assign o_sts.out_free  = w_out_free;

    // control state of the series
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_prev  <= '0;
            r_first <= '0;
            r_slope <= SL_NONE;
            r_flat  <= '0;
            r_sidx  <= '0;
            r_maxc  <= '0;
            r_minc  <= '0;
            r_good  <= 1'b1;
        end else if (i_cmd.step) begin
            if (r_sidx == '0) begin
                r_first <= r_smp;
            end else if (w_rise) begin
                if (w_emit_min) begin
                    r_minc <= inc1(r_minc);
                    if (r_prev >= 0) begin
                        r_good <= 1'b0;
                    end
                end
                r_slope <= SL_UP;
                r_flat  <= '0;
            end else if (w_fall) begin
                if (w_emit_max) begin
                    r_maxc <= inc1(r_maxc);
                    if (r_prev <= 0) begin
                        r_good <= 1'b0;
                    end
                end
                r_slope <= SL_DOWN;
                r_flat  <= '0;
            end else begin
                r_flat <= inc1(r_flat);
            end
            r_prev <= r_smp;
            if (r_sidx <= LIM) begin
                r_sidx <= r_sidx + 1'b1;
            end
        end
    end

    // payload: held sample, point lists, extrapolation
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_smp  <= i_sample;
            r_last <= i_last;
        end
        if (i_cmd.step) begin
            r_tpos <= {w_idx, 1'b0};
            if (w_emit_min) begin
                if (r_minc < CW'(2)) begin
                    r_emn_p[r_minc[0]] <= w_ppos;
                    r_emn_v[r_minc[0]] <= r_prev;
                end
                r_rmn_p[0] <= r_rmn_p[1];
                r_rmn_v[0] <= r_rmn_v[1];
                r_rmn_p[1] <= w_ppos;
                r_rmn_v[1] <= r_prev;
            end
            if (w_emit_max) begin
                if (r_maxc < CW'(2)) begin
                    r_emx_p[r_maxc[0]] <= w_ppos;
                    r_emx_v[r_maxc[0]] <= r_prev;
                end
                r_rmx_p[0] <= r_rmx_p[1];
                r_rmx_v[0] <= r_rmx_v[1];
                r_rmx_p[1] <= w_ppos;
                r_rmx_v[1] <= r_prev;
            end
        end
        if (i_cmd.ep_init) begin
            r_val <= i_cmd.ep[0] ? fix(r_smp) : fix(r_first);
        end
        if (i_cmd.mul) begin
            r_p1 <= w_av * w_sden;
            r_p2 <= w_diff * w_dt;
        end
        if (i_cmd.sum) begin
            r_neg <= (w_num < 0);
            r_mag <= (w_num < 0) ? NUM_W'(-w_num) : NUM_W'(w_num);
        end
        if (i_cmd.fin && w_take) begin
            r_val <= w_e;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((i_cmd.step && o_sts.step_emit) || i_cmd.emit_ep || i_cmd.emit_one) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.step && o_sts.step_emit) begin
            r_o_kind <= w_emit_min ? eef_pkg::KIND_MIN : eef_pkg::KIND_MAX;
            r_o_ord  <= w_emit_min ? inc1(r_minc) : inc1(r_maxc);
            r_o_pos  <= w_ppos;
            r_o_val  <= fix(r_prev);
            r_o_fin  <= 1'b0;
            r_o_mc   <= '0;
            r_o_nc   <= '0;
            r_o_good <= 1'b0;
        end else if (i_cmd.emit_one) begin
            r_o_kind <= i_cmd.one_min ? eef_pkg::KIND_MIN : eef_pkg::KIND_MAX;
            r_o_ord  <= '0;
            r_o_pos  <= '0;
            r_o_val  <= fix(r_smp);
            r_o_fin  <= i_cmd.one_min;
            r_o_mc   <= i_cmd.one_min ? CW'(1) : '0;
            r_o_nc   <= i_cmd.one_min ? CW'(1) : '0;
            r_o_good <= i_cmd.one_min;
        end else if (i_cmd.emit_ep) begin
            r_o_kind <= i_cmd.ep[1] ? eef_pkg::KIND_MIN : eef_pkg::KIND_MAX;
            r_o_ord  <= !i_cmd.ep[0] ? '0 : (i_cmd.ep[1] ? inc1(r_minc) : inc1(r_maxc));
            r_o_pos  <= i_cmd.ep[0] ? r_tpos : '0;
            r_o_val  <= r_val;
            r_o_fin  <= (i_cmd.ep == eef_pkg::EP_RMIN);
            r_o_mc   <= (i_cmd.ep == eef_pkg::EP_RMIN) ? inc2(r_maxc) : '0;
            r_o_nc   <= (i_cmd.ep == eef_pkg::EP_RMIN) ? inc2(r_minc) : '0;
            r_o_good <= (i_cmd.ep == eef_pkg::EP_RMIN) && r_good;
        end else begin
            r_o_kind <= r_o_kind;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_kind          = r_o_kind;
    assign o_ordinal       = r_o_ord;
    assign o_position_half = eef_pkg::POSH_W'(r_o_pos);
    assign o_value         = r_o_val;
    assign o_final_res     = r_o_fin;
    assign o_max_count     = r_o_mc;
    assign o_min_count     = r_o_nc;
    assign o_all_good      = r_o_good;
endmodule

### hdl/eef_ctrl.sv
// sequencer for sample steps and the end-of-series endpoint burst
module eef_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  eef_pkg::t_sts i_sts,
    input  logic          i_div_done,
    output logic          o_div_start,
    output eef_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_ONE_MAX,
        S_ONE_MIN,
        S_EP_INIT,
        S_MUL,
        S_SUM,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic [1:0] r_ep;
    logic       w_step_go;

    assign w_step_go = !i_sts.step_emit || i_sts.out_free;

    // state and endpoint counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ep    <= eef_pkg::EP_LMAX;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (w_step_go) begin
                        r_ep <= eef_pkg::EP_LMAX;
                        if (!i_sts.last) begin
                            r_state <= S_IDLE;
                        end else if (i_sts.one) begin
                            r_state <= S_ONE_MAX;
                        end else begin
                            r_state <= S_EP_INIT;
                        end
                    end
                end
                S_ONE_MAX: begin
                    if (i_sts.out_free) begin
                        r_state <= S_ONE_MIN;
                    end
                end
                S_ONE_MIN: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EP_INIT: begin
                    r_state <= i_sts.ep_try ? S_MUL : S_EMIT;
                end
                S_MUL:      r_state <= S_SUM;
                S_SUM:      r_state <= S_DIV_GO;
                S_DIV_GO:   r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (i_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN:      r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        if (r_ep == eef_pkg::EP_RMIN) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ep    <= r_ep + 2'd1;
                            r_state <= S_EP_INIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.ep       = r_ep;
        o_in_ready     = (r_state == S_IDLE) && i_rst_n;
        o_div_start    = (r_state == S_DIV_GO);
        o_cmd.step     = (r_state == S_STEP) && w_step_go;
        o_cmd.ep_init  = (r_state == S_EP_INIT);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.fin      = (r_state == S_FIN);
        o_cmd.emit_ep  = (r_state == S_EMIT) && i_sts.out_free;
        o_cmd.emit_one = ((r_state == S_ONE_MAX) || (r_state == S_ONE_MIN)) && i_sts.out_free;
        o_cmd.one_min  = (r_state == S_ONE_MIN);
        o_cmd.clear    = i_sts.out_free &&
                         ((r_state == S_ONE_MIN) ||
                          ((r_state == S_EMIT) && (r_ep == eef_pkg::EP_RMIN)));
    end
endmodule

### hdl/envelope_extrema_finder.sv
// top level of the envelope extrema finder
//
//  channel  dir  signals                                    request
//  i_in     in   valid ready sample last                    one sample
//  o_out    out  valid ready kind ordinal position_half     one list entry
//                value final_res max_count min_count all_good
//
// each sample passes through the idle and step states; a sample that reveals an
// extremum waits in its step until the output register is free.
// on the last sample the four endpoints follow, each through init and emit plus,
// where it extrapolates, multiply, sum, divider start, divider wait and compare;
// the serial divider gives SAMPLE_BITS + clog2(MAX_LENGTH+1) + 4 + FRACTION_BITS bits.
// synchronous active-low reset; a stalled output holds its entry and the
// sequencer waits, no request is dropped.
module envelope_extrema_finder #(
    parameter int SAMPLE_BITS   = eef_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_LENGTH    = eef_pkg::MAX_LENGTH_DEF,
    parameter int FRACTION_BITS = eef_pkg::FRACTION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eef_in_if.sink    i_in,
    eef_out_if.source o_out
);
    localparam int POS_W = $clog2(MAX_LENGTH + 1) + 1;
    localparam int DVD_W = SAMPLE_BITS + POS_W + 3 + FRACTION_BITS;

    eef_pkg::t_cmd    w_cmd;
    eef_pkg::t_sts    w_sts;
    logic             w_in_ready;
    logic             w_div_start;
    logic             w_div_done;
    logic [DVD_W-1:0] w_dvd;
    logic [DVD_W-1:0] w_quo;
    logic [POS_W-1:0] w_den;

    assign i_in.ready = w_in_ready;

    // sequencer
    eef_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_sts       (w_sts),
        .i_div_done  (w_div_done),
        .o_div_start (w_div_start),
        .o_cmd       (w_cmd)
    );

    // datapath
    eef_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .MAX_LENGTH    (MAX_LENGTH),
        .FRACTION_BITS (FRACTION_BITS),
        .POS_W         (POS_W),
        .DVD_W         (DVD_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (i_in.valid && w_in_ready),
        .i_sample        (i_in.sample),
        .i_last          (i_in.last),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_dvd           (w_dvd),
        .o_den           (w_den),
        .i_quo           (w_quo),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_kind          (o_out.kind),
        .o_ordinal       (o_out.ordinal),
        .o_position_half (o_out.position_half),
        .o_value         (o_out.value),
        .o_final_res     (o_out.final_res),
        .o_max_count     (o_out.max_count),
        .o_min_count     (o_out.min_count),
        .o_all_good      (o_out.all_good)
    );

    // shared serial divider
    eef_div #(
        .DVD_W (DVD_W),
        .DEN_W (POS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dvd   (w_dvd),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );
endmodule
